[hdl/fvs_pkg.sv]
// ---------------------------------------------------------------------------
// fvs_pkg: shared types and constants for field value statistics
// Table geometry, field widths, shared unit operations and helper functions.
// ---------------------------------------------------------------------------
package fvs_pkg;

    // distinct-value table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int UNIQ_W      = $clog2(TABLE_DEPTH + 1);

    // field and counter widths
    localparam int VAL_W   = 64;
    localparam int CNT_W   = 32;
    localparam int SUMH_W  = 32;
    localparam int CFG_W   = 7;
    localparam int MAX_WIDTH = 64;

    // stream data widths
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 400;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_FIELD_WIDTH = 3'd0;
    localparam logic [CFG_W-1:0]  FIELD_WIDTH_RESET = 7'd8;

    // shared arithmetic unit operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_LT,
        ALU_EQ
    } alu_op_t;

    typedef struct packed {
        logic [VAL_W-1:0] sum;
        logic             carry;
        logic             flag;
    } alu_res_t;

    // table access request from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [TBL_AW-1:0] rd_addr;
        logic              wr_en;
        logic [TBL_AW-1:0] wr_addr;
        logic [VAL_W-1:0]  wr_key;
        logic [CNT_W-1:0]  wr_count;
        logic              clr;
    } tbl_req_t;

    // low-bit mask for the configured field width, clamped to MAX_WIDTH
    function automatic logic [VAL_W-1:0] field_mask(input logic [CFG_W-1:0] w);
        logic [VAL_W-1:0] m;
        m = '0;
        if (w == '0) begin
            m = '0;
        end else if (w >= CFG_W'(MAX_WIDTH)) begin
            m = {VAL_W{1'b1}};
        end else begin
            m = ~({VAL_W{1'b1}} << w);
        end
        return m;
    endfunction

    // xor fold of the value down to a table index
    function automatic logic [TBL_AW-1:0] hash_index(input logic [VAL_W-1:0] v);
        logic [TBL_AW-1:0] h;
        h = '0;
        for (int i = 0; i < VAL_W; i++) begin
            h[i % TBL_AW] = h[i % TBL_AW] ^ v[i];
        end
        return h;
    endfunction

    // saturating increment of a count
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x == {CNT_W{1'b1}}) ? x : x + CNT_W'(1);
    endfunction

endpackage

[hdl/fvs_alu.sv]
// ---------------------------------------------------------------------------
// fvs_alu: shared 64-bit add and compare unit
// One adder with carry out and one magnitude/equality compare, selected by op.
// ---------------------------------------------------------------------------
module fvs_alu
    import fvs_pkg::*;
(
    input  alu_op_t          op,
    input  logic [VAL_W-1:0] a,
    input  logic [VAL_W-1:0] b,
    output alu_res_t         res
);

    logic [VAL_W:0] add_full;

    // wide add with carry out
    assign add_full = {1'b0, a} + {1'b0, b};

    // operation select
    always_comb begin
        res.sum   = add_full[VAL_W-1:0];
        res.carry = add_full[VAL_W];
        case (op)
            ALU_ADD: res.flag = add_full[VAL_W];
            ALU_LT:  res.flag = (a < b);
            ALU_EQ:  res.flag = (a == b);
            default: res.flag = 1'b0;
        endcase
    end

endmodule

[hdl/fvs_table.sv]
// ---------------------------------------------------------------------------
// fvs_table: distinct-value table
// Key and count memories with one write and one registered read port, plus
// per-entry valid bits that all clear together at the end of a run.
// ---------------------------------------------------------------------------
module fvs_table
    import fvs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  tbl_req_t         req,
    output logic [VAL_W-1:0] rd_key,
    output logic [CNT_W-1:0] rd_count,
    output logic             rd_valid
);

    logic [VAL_W-1:0]       key_mem   [TABLE_DEPTH];
    logic [CNT_W-1:0]       count_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [VAL_W-1:0]       rd_key_reg;
    logic [CNT_W-1:0]       rd_count_reg;
    logic                   rd_valid_reg;

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            key_mem[req.wr_addr]   <= req.wr_key;
            count_mem[req.wr_addr] <= req.wr_count;
        end
        if (req.rd_en) begin
            rd_key_reg   <= key_mem[req.rd_addr];
            rd_count_reg <= count_mem[req.rd_addr];
        end
    end

    // valid bits, cleared at reset and at end of run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
            if (req.clr) begin
                valid_reg <= '0;
            end else if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_key   = rd_key_reg;
    assign rd_count = rd_count_reg;
    assign rd_valid = rd_valid_reg;

endmodule

[hdl/field_value_statistics.sv]
// ---------------------------------------------------------------------------
// field_value_statistics: streaming statistics over one field of a frame run
// Counts, distinct values, mode, min, max, 96-bit sum and monotonic flag.
// ---------------------------------------------------------------------------
// Usage: each input beat carries one frame's field on s_tdata, the present
// flag on s_tuser and the last-row mark on s_tlast. A missing field is only
// counted. A beat with s_tlast high ends the run: one summary beat leaves on
// the m_ channel and all statistics clear. Other beats produce no output.
// field_width is written over the APB port at byte address 0 (reset 8).
// Steps: a missing field passes through S_DONE back to idle. A present value
// passes through the min, max, sum and order steps, then k hashed table probes
// (1 when the slot is free or matches, up to 256 when the table is full), then
// S_DONE; each probe is a registered memory read followed by a compare in the
// shared 64-bit unit, which also does the min, max, sum and order steps. A last
// row then waits in S_EMIT until the summary register is free to load.
// s_tready is high only while the sequencer is idle. The summary register
// holds a result until m_tready takes it; a new run may proceed meanwhile,
// and only its own summary waits for the register to free.
// Reset clears all statistics, the table valid bits and the output register.
// ---------------------------------------------------------------------------
module field_value_statistics
    import fvs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [63:0] field_value
    input  logic                s_tuser,   // [0] field_present
    input  logic                s_tlast,
    // summary stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [31:0] analyzed_count, [63:32] missing_count,
                                           // [72:64] unique_count, [73] table_full,
                                           // [137:74] min_value, [201:138] max_value,
                                           // [265:202] sum_low, [297:266] sum_high,
                                           // [361:298] mode_value, [393:362] mode_count,
                                           // [394] is_constant, [395] is_monotonic,
                                           // [399:396] zero
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIN,
        S_MAX,
        S_SUM,
        S_MONO,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_DONE,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [CFG_W-1:0]    field_width_reg;
    logic [VAL_W-1:0]    value_reg;
    logic                last_reg;
    logic [TBL_AW-1:0]   probe_addr_reg;
    logic [TBL_AW-1:0]   probe_cnt_reg;

    logic [CNT_W-1:0]    present_reg;
    logic [CNT_W-1:0]    absent_reg;
    logic [UNIQ_W-1:0]   distinct_reg;
    logic                overflow_reg;
    logic [VAL_W-1:0]    low_reg;
    logic [VAL_W-1:0]    high_reg;
    logic [VAL_W-1:0]    sum_lo_reg;
    logic [SUMH_W-1:0]   sum_hi_reg;
    logic [VAL_W-1:0]    top_value_reg;
    logic [CNT_W-1:0]    top_count_reg;
    logic [VAL_W-1:0]    prev_reg;
    logic                prev_seen_reg;
    logic                rising_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    alu_op_t             alu_op;
    logic [VAL_W-1:0]    alu_a;
    logic [VAL_W-1:0]    alu_b;
    alu_res_t            alu_res;

    tbl_req_t            tbl_req;
    logic [VAL_W-1:0]    rd_key;
    logic [CNT_W-1:0]    rd_count;
    logic                rd_valid;

    logic [CNT_W-1:0]    hit_count;
    logic                cfg_wr;
    logic                in_beat;
    logic                out_free;
    logic [M_DATA_W-1:0] summary;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_FIELD_WIDTH);
    assign prdata = (paddr == ADDR_FIELD_WIDTH) ?
                    {{(APB_DW-CFG_W){1'b0}}, field_width_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_width_reg <= FIELD_WIDTH_RESET;
        end else if (cfg_wr) begin
            field_width_reg <= pwdata[CFG_W-1:0];
        end
    end

    // handshakes
    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // shared unit operand select
    always_comb begin
        alu_op = ALU_LT;
        alu_a  = value_reg;
        alu_b  = low_reg;
        case (state_reg)
            S_MIN: begin
                alu_op = ALU_LT;
                alu_a  = value_reg;
                alu_b  = low_reg;
            end
            S_MAX: begin
                alu_op = ALU_LT;
                alu_a  = high_reg;
                alu_b  = value_reg;
            end
            S_SUM: begin
                alu_op = ALU_ADD;
                alu_a  = sum_lo_reg;
                alu_b  = value_reg;
            end
            S_MONO: begin
                alu_op = ALU_LT;
                alu_a  = value_reg;
                alu_b  = prev_reg;
            end
            S_PROBE_CMP: begin
                alu_op = ALU_EQ;
                alu_a  = rd_key;
                alu_b  = value_reg;
            end
            default: begin
                alu_op = ALU_LT;
                alu_a  = value_reg;
                alu_b  = low_reg;
            end
        endcase
    end

    fvs_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // count written back on a hit or on a fresh entry
    assign hit_count = rd_valid ? sat_inc(rd_count) : CNT_W'(1);

    // table requests
    always_comb begin
        tbl_req          = '0;
        tbl_req.rd_addr  = probe_addr_reg;
        tbl_req.wr_addr  = probe_addr_reg;
        tbl_req.wr_key   = value_reg;
        tbl_req.wr_count = hit_count;
        tbl_req.rd_en    = (state_reg == S_PROBE_RD);
        tbl_req.wr_en    = (state_reg == S_PROBE_CMP) && (!rd_valid || alu_res.flag);
        tbl_req.clr      = (state_reg == S_EMIT) && out_free;
    end

    fvs_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (tbl_req),
        .rd_key   (rd_key),
        .rd_count (rd_count),
        .rd_valid (rd_valid)
    );

    // summary beat packing
    assign summary = {
        4'b0,
        rising_reg && (present_reg >= CNT_W'(2)),
        (distinct_reg == UNIQ_W'(1)) && (present_reg != '0),
        top_count_reg,
        top_value_reg,
        sum_hi_reg,
        sum_lo_reg,
        high_reg,
        low_reg,
        overflow_reg,
        distinct_reg,
        absent_reg,
        present_reg
    };

    // sequencer, statistics and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            probe_addr_reg <= '0;
            probe_cnt_reg  <= '0;
            present_reg    <= '0;
            absent_reg     <= '0;
            distinct_reg   <= '0;
            overflow_reg   <= 1'b0;
            low_reg        <= {VAL_W{1'b1}};
            high_reg       <= '0;
            sum_lo_reg     <= '0;
            sum_hi_reg     <= '0;
            top_value_reg  <= '0;
            top_count_reg  <= '0;
            prev_reg       <= '0;
            prev_seen_reg  <= 1'b0;
            rising_reg     <= 1'b1;
            m_tvalid_reg   <= 1'b0;
            last_reg       <= 1'b0;
        end else begin
            // a taken beat frees the register unless a new summary loads it
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_beat) begin
                        value_reg <= s_tdata & field_mask(field_width_reg);
                        last_reg  <= s_tlast;
                        if (s_tuser) begin
                            present_reg <= sat_inc(present_reg);
                            state_reg   <= S_MIN;
                        end else begin
                            absent_reg <= sat_inc(absent_reg);
                            state_reg  <= S_DONE;
                        end
                    end
                end
                S_MIN: begin
                    if (alu_res.flag) begin
                        low_reg <= value_reg;
                    end
                    state_reg <= S_MAX;
                end
                S_MAX: begin
                    if (alu_res.flag) begin
                        high_reg <= value_reg;
                    end
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    sum_lo_reg <= alu_res.sum;
                    if (alu_res.carry) begin
                        sum_hi_reg <= sum_hi_reg + SUMH_W'(1);
                    end
                    state_reg <= S_MONO;
                end
                S_MONO: begin
                    if (prev_seen_reg && alu_res.flag) begin
                        rising_reg <= 1'b0;
                    end
                    prev_reg       <= value_reg;
                    prev_seen_reg  <= 1'b1;
                    probe_addr_reg <= hash_index(value_reg);
                    probe_cnt_reg  <= '0;
                    state_reg      <= S_PROBE_RD;
                end
                S_PROBE_RD: begin
                    state_reg <= S_PROBE_CMP;
                end
                S_PROBE_CMP: begin
                    if (!rd_valid || alu_res.flag) begin
                        // free slot takes the value, or a match bumps its count
                        if (!rd_valid) begin
                            distinct_reg <= distinct_reg + UNIQ_W'(1);
                        end
                        if (hit_count > top_count_reg) begin
                            top_count_reg <= hit_count;
                            top_value_reg <= value_reg;
                        end
                        state_reg <= S_DONE;
                    end else if (probe_cnt_reg == TBL_AW'(TABLE_DEPTH - 1)) begin
                        // every slot probed: table full
                        overflow_reg <= 1'b1;
                        state_reg    <= S_DONE;
                    end else begin
                        probe_cnt_reg  <= probe_cnt_reg + TBL_AW'(1);
                        probe_addr_reg <= probe_addr_reg + TBL_AW'(1);
                        state_reg      <= S_PROBE_RD;
                    end
                end
                S_DONE: begin
                    state_reg <= last_reg ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg  <= 1'b1;
                        m_tdata_reg   <= summary;
                        present_reg   <= '0;
                        absent_reg    <= '0;
                        distinct_reg  <= '0;
                        overflow_reg  <= 1'b0;
                        low_reg       <= {VAL_W{1'b1}};
                        high_reg      <= '0;
                        sum_lo_reg    <= '0;
                        sum_hi_reg    <= '0;
                        top_value_reg <= '0;
                        top_count_reg <= '0;
                        prev_reg      <= '0;
                        prev_seen_reg <= 1'b0;
                        rising_reg    <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
